// ----- design/doy2ep_pkg.sv -----
`default_nettype none
package doy2ep_pkg;

    localparam int FRACTION_BITS = 20;

    localparam int YEAR_W    = 8;
    localparam int YDAY_W    = 9;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECONDS_W = 26;
    localparam int EPOCH_W   = 34;
    localparam int NANOS_W   = 30;

    localparam int LEAP_W = 7;
    localparam int YDAYS_W = 17;
    localparam int DAYS_W = 18;
    localparam int SOD_W = 28;
    localparam int PROD_W = FRACTION_BITS + NANOS_W;

    localparam logic [YEAR_W-1:0] CENTURY_SKIP = 8'd200;
    localparam logic signed [DAYS_W-1:0] DAY_BIAS = 18'sd25568;
    localparam logic signed [EPOCH_W-1:0] SECS_PER_DAY = 34'sd86400;
    localparam logic [NANOS_W-1:0] NANOS_PER_SEC = 30'd1000000000;

    function automatic logic [LEAP_W-1:0] leap_count(input logic [YEAR_W-1:0] y);
        logic [YEAR_W:0] rounded;
        logic [LEAP_W-1:0] cnt;
        begin
            rounded = {1'b0, y} + 9'd3;
            cnt = LEAP_W'(rounded >> 2);
            if (y != '0)
            begin
                cnt = cnt - 7'd1;
            end
            if (y > CENTURY_SKIP)
            begin
                cnt = cnt - 7'd1;
            end
            return cnt;
        end
    endfunction

endpackage
`default_nettype wire

// ----- design/doy2ep_in_if.sv -----
`default_nettype none
interface doy2ep_in_if;
    import doy2ep_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [YEAR_W-1:0]     years_since_1900;
    logic [YDAY_W-1:0]     day_of_year;
    logic [HOUR_W-1:0]     hour_of_day;
    logic [MINUTE_W-1:0]   minute_of_hour;
    logic [SECONDS_W-1:0]  seconds_fixed;

    modport source (
        output valid, years_since_1900, day_of_year, hour_of_day, minute_of_hour,
               seconds_fixed,
        input  ready
    );

    modport sink (
        input  valid, years_since_1900, day_of_year, hour_of_day, minute_of_hour,
               seconds_fixed,
        output ready
    );
endinterface
`default_nettype wire

// ----- design/doy2ep_out_if.sv -----
`default_nettype none
interface doy2ep_out_if;
    import doy2ep_pkg::*;

    logic                valid;
    logic                ready;
    logic [EPOCH_W-1:0]  epoch_seconds;
    logic [NANOS_W-1:0]  nanoseconds;

    modport source (
        output valid, epoch_seconds, nanoseconds,
        input  ready
    );

    modport sink (
        input  valid, epoch_seconds, nanoseconds,
        output ready
    );
endinterface
`default_nettype wire

// ----- design/day_of_year_to_epoch_time.sv -----
// Converts a UTC timestamp (years since 1900, day of year, hour, minute and
// fixed-point seconds) into signed seconds since 1970-01-01 and truncated
// nanoseconds, one word per cycle unless the output stalls. Each word passes
// through three register stages; the last stage is the output register. The day
// count and the fraction multiply are in stage one, the seconds-per-day multiply
// in stage two and the final add in stage three. A stalled output holds its word
// while earlier stages keep filling.
`default_nettype none
module day_of_year_to_epoch_time (
    input  wire logic     clk,
    input  wire logic     rst_n,
    doy2ep_in_if.sink     timestamp,
    doy2ep_out_if.source  epoch
);
    import doy2ep_pkg::*;

    logic en1, en2, en3;

    logic                      v1_reg;
    logic signed [DAYS_W-1:0]  days1_reg, days1_next;
    logic [SOD_W-1:0]          sod1_reg, sod1_next;
    logic [PROD_W-1:0]         prod1_reg, prod1_next;

    logic                      v2_reg;
    logic [EPOCH_W-1:0]        days_sec2_reg, days_sec2_next;
    logic [SOD_W-1:0]          sod2_reg;
    logic [NANOS_W-1:0]        nanos2_reg, nanos2_next;

    logic                      v3_reg;
    logic [EPOCH_W-1:0]        epoch3_reg, epoch3_next;
    logic [NANOS_W-1:0]        nanos3_reg;

    logic [YDAYS_W-1:0]        year_days;
    logic [SOD_W-1:0]          whole_sec;
    logic [FRACTION_BITS-1:0]  frac;
    logic signed [EPOCH_W-1:0] days_wide;

    assign en3 = !v3_reg || epoch.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign timestamp.ready = en1;

    always_comb
    begin
        year_days = YDAYS_W'(timestamp.years_since_1900) * YDAYS_W'(365)
                  + YDAYS_W'(leap_count(timestamp.years_since_1900))
                  + YDAYS_W'(timestamp.day_of_year);
        days1_next = $signed({1'b0, year_days}) - DAY_BIAS;
        whole_sec = SOD_W'(timestamp.seconds_fixed >> FRACTION_BITS);
        sod1_next = SOD_W'(timestamp.hour_of_day) * SOD_W'(3600)
                  + SOD_W'(timestamp.minute_of_hour) * SOD_W'(60)
                  + whole_sec;
        frac = FRACTION_BITS'(timestamp.seconds_fixed);
        prod1_next = PROD_W'(frac) * PROD_W'(NANOS_PER_SEC);
    end

    always_comb
    begin
        days_wide = EPOCH_W'(days1_reg);
        days_sec2_next = EPOCH_W'(days_wide * SECS_PER_DAY);
        nanos2_next = NANOS_W'(prod1_reg >> FRACTION_BITS);
    end

    assign epoch3_next = days_sec2_reg + EPOCH_W'(sod2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= timestamp.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && timestamp.valid)
        begin
            days1_reg <= days1_next;
            sod1_reg  <= sod1_next;
            prod1_reg <= prod1_next;
        end
        if (en2 && v1_reg)
        begin
            days_sec2_reg <= days_sec2_next;
            sod2_reg      <= sod1_reg;
            nanos2_reg    <= nanos2_next;
        end
        if (en3 && v2_reg)
        begin
            epoch3_reg <= epoch3_next;
            nanos3_reg <= nanos2_reg;
        end
    end

    assign epoch.valid         = v3_reg;
    assign epoch.epoch_seconds = epoch3_reg;
    assign epoch.nanoseconds   = nanos3_reg;

    // A word stuck in the middle stage keeps its value until it moves on.
    assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !en3 |=> v2_reg && $stable(days_sec2_reg) && $stable(nanos2_reg))
    else $error("middle stage word changed while stalled");

    // The fraction of a second never reaches a full second.
    assert property (@(posedge clk) disable iff (!rst_n)
        epoch.valid |-> epoch.nanoseconds < NANOS_PER_SEC)
    else $error("nanoseconds out of range");

    // A full first stage that cannot advance keeps its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !en2 |=> v1_reg && $stable(days1_reg) && $stable(sod1_reg)
                           && $stable(prod1_reg))
    else $error("first stage word lost under stall");

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import doy2ep_pkg::*;

    localparam int RANDOM_STAMPS = 1530;
    localparam int HOLD_AT_WORD = 500;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [SECONDS_W-1:0] SECONDS_BELOW_62 = 26'd65011711;

    typedef struct {
        logic [YEAR_W-1:0]    year;
        logic [YDAY_W-1:0]    yday;
        logic [HOUR_W-1:0]    hour;
        logic [MINUTE_W-1:0]  minute;
        logic [SECONDS_W-1:0] seconds;
        int                   gap;
        bit                   drain_first;
    } stamp_t;

    typedef struct {
        logic [EPOCH_W-1:0] secs;
        logic [NANOS_W-1:0] nanos;
    } epoch_word_t;

    logic clk;
    logic rst_n;

    doy2ep_in_if  ts_if ();
    doy2ep_out_if ep_if ();

    day_of_year_to_epoch_time uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .timestamp (ts_if),
        .epoch     (ep_if)
    );

    stamp_t      stamp_q[$];
    epoch_word_t pending_epochs[$];
    stamp_t      cur_stamp;
    bit          cur_busy;
    int          gap_left;
    bit          stamp_taken;
    bit          epoch_taken;
    int          stamps_in;
    int          epochs_out;
    int          total_stamps;
    int          err_count;
    int          stall_left;
    int          hold_left;
    bit          hold_done;
    int          cycle_count;

    function automatic longint leaps_prior(longint y);
        longint p;
        begin
            p = y - 1;
            return p / 4 - p / 100 + p / 400;
        end
    endfunction

    function automatic epoch_word_t calc_epoch(stamp_t s);
        longint year;
        longint days;
        longint whole;
        longint total;
        longint unsigned frac;
        longint unsigned nanos;
        epoch_word_t w;
        begin
            year = 1900 + longint'(s.year);
            days = 365 * (year - 1970) + leaps_prior(year) - leaps_prior(1970)
                + longint'(s.yday) - 1;
            whole = longint'(s.seconds) >>> FRACTION_BITS;
            frac = longint'(s.seconds) & ((64'd1 << FRACTION_BITS) - 1);
            total = days * 86400 + longint'(s.hour) * 3600 + longint'(s.minute) * 60 + whole;
            nanos = (frac * 64'd1000000000) >> FRACTION_BITS;
            w.secs = total[EPOCH_W-1:0];
            w.nanos = nanos[NANOS_W-1:0];
            return w;
        end
    endfunction

    task automatic add_stamp(input int y, input int d, input int h, input int m,
                             input logic [SECONDS_W-1:0] sec, input int gap, input bit drain);
        stamp_t s;
        begin
            s.year = YEAR_W'(y);
            s.yday = YDAY_W'(d);
            s.hour = HOUR_W'(h);
            s.minute = MINUTE_W'(m);
            s.seconds = sec;
            s.gap = gap;
            s.drain_first = drain;
            stamp_q.push_back(s);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        int day_pick[4];
        int y;
        int d;
        int h;
        int m;
        int g;
        logic [SECONDS_W-1:0] sec;
        rst_n = 1'b0;
        ts_if.valid = 1'b0;
        ts_if.years_since_1900 = '0;
        ts_if.day_of_year = '0;
        ts_if.hour_of_day = '0;
        ts_if.minute_of_hour = '0;
        ts_if.seconds_fixed = '0;
        ep_if.ready = 1'b0;
        day_pick = '{0, 1, 365, 366};

        add_stamp(70, 1, 0, 0, 0, 0, 0);
        add_stamp(0, 0, 0, 0, 0, 0, 0);
        add_stamp(0, 1, 0, 0, 0, 1, 0);
        add_stamp(255, 511, 31, 63, '1, 0, 0);
        add_stamp(0, 511, 31, 63, SECONDS_BELOW_62, 0, 0);
        add_stamp(100, 60, 12, 30, 26'd1, 2, 0);
        add_stamp(100, 366, 23, 59, SECONDS_BELOW_62, 0, 0);
        add_stamp(101, 0, 0, 0, 0, 0, 0);
        add_stamp(200, 366, 0, 0, 26'hFFFFF, 0, 0);
        add_stamp(199, 366, 1, 1, 26'h100000, 3, 0);
        add_stamp(72, 366, 0, 0, 0, 0, 0);
        add_stamp(71, 365, 23, 59, 26'd62914560, 0, 0);
        add_stamp(104, 60, 0, 0, 0, 0, 0);
        add_stamp(111, 400, 30, 0, 0, 0, 0);
        add_stamp(69, 365, 23, 59, 26'd61865984, 17, 0);
        add_stamp(138, 19, 3, 14, 26'd8388608, 0, 0);
        add_stamp(150, 256, 16, 32, 26'h2AAAAAA, 0, 0);
        add_stamp(85, 128, 8, 0, 26'h1555555, 0, 0);
        add_stamp(255, 0, 0, 0, 26'h3F00000, 0, 0);
        add_stamp(170, 200, 31, 63, 26'hFFFFF, 5, 0);

        for (int i = 0; i < RANDOM_STAMPS; i++)
        begin
            y = $urandom_range(0, 255);
            case ($urandom_range(0, 9))
                6, 7: d = $urandom_range(0, 511);
                8: d = day_pick[2'($urandom_range(0, 3))];
                9: d = $urandom_range(360, 367);
                default: d = $urandom_range(1, 365);
            endcase
            h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23);
            m = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
            case ($urandom_range(0, 9))
                7: sec = SECONDS_W'($urandom());
                8: sec = {6'($urandom_range(0, 63)), 20'hFFFFF};
                9: sec = {6'($urandom_range(0, 61)), 20'h00000};
                default: sec = SECONDS_W'($urandom_range(0, SECONDS_BELOW_62));
            endcase
            g = (((i / 100) % 3) != 0) ? $urandom_range(0, 17) : 0;
            add_stamp(y, d, h, m, sec, g, (i == 0) || (i == RANDOM_STAMPS / 2));
        end
        total_stamps = stamp_q.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (stamps_in != total_stamps)
        begin
            @(posedge clk);
        end
        while (pending_epochs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Converted %0d timestamps: corner dates, leap and century years, day zero,",
                 stamps_in);
        $display("rollover and out-of-range fields under random gaps, stalls and a long hold.");
        if (err_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        stamp_t s;
        epoch_word_t want;
        if (rst_n)
        begin
            epoch_taken = ep_if.valid && ep_if.ready;
            if (epoch_taken)
            begin
                epochs_out++;
                if (pending_epochs.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected word, epoch_seconds %0d, nanoseconds %0d",
                             $time, $signed(ep_if.epoch_seconds), ep_if.nanoseconds);
                end
                else
                begin
                    want = pending_epochs.pop_front();
                    if (ep_if.epoch_seconds !== want.secs)
                    begin
                        err_count++;
                        $display("%0t: epoch_seconds expected %0d, actual %0d", $time,
                                 $signed(want.secs), $signed(ep_if.epoch_seconds));
                    end
                    if (ep_if.nanoseconds !== want.nanos)
                    begin
                        err_count++;
                        $display("%0t: nanoseconds expected %0d, actual %0d", $time,
                                 want.nanos, ep_if.nanoseconds);
                    end
                end
            end
            stamp_taken = ts_if.valid && ts_if.ready;
            if (stamp_taken)
            begin
                s.year = ts_if.years_since_1900;
                s.yday = ts_if.day_of_year;
                s.hour = ts_if.hour_of_day;
                s.minute = ts_if.minute_of_hour;
                s.seconds = ts_if.seconds_fixed;
                pending_epochs.push_back(calc_epoch(s));
                stamps_in++;
            end
        end
    end

    always @(negedge clk)
    begin
        bit offer;
        if (rst_n)
        begin
            if (ts_if.valid && stamp_taken)
            begin
                cur_busy = 1'b0;
            end
            offer = ts_if.valid && !stamp_taken;
            if (!offer)
            begin
                if (!cur_busy && stamp_q.size() > 0)
                begin
                    cur_stamp = stamp_q.pop_front();
                    cur_busy = 1'b1;
                    gap_left = cur_stamp.gap;
                end
                if (cur_busy)
                begin
                    if (cur_stamp.drain_first && pending_epochs.size() != 0)
                    begin
                        offer = 1'b0;
                    end
                    else if (gap_left > 0)
                    begin
                        gap_left--;
                    end
                    else
                    begin
                        offer = 1'b1;
                    end
                end
            end
            ts_if.valid <= offer;
            if (offer)
            begin
                ts_if.years_since_1900 <= cur_stamp.year;
                ts_if.day_of_year <= cur_stamp.yday;
                ts_if.hour_of_day <= cur_stamp.hour;
                ts_if.minute_of_hour <= cur_stamp.minute;
                ts_if.seconds_fixed <= cur_stamp.seconds;
            end
        end
    end

    always @(negedge clk)
    begin
        bit rdy;
        if (rst_n)
        begin
            if (!hold_done && stamps_in >= HOLD_AT_WORD)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                if (epoch_taken)
                begin
                    stall_left = (((epochs_out / 120) % 3) == 1) ? 0 : $urandom_range(0, 17);
                end
                if (stall_left > 0)
                begin
                    stall_left--;
                    rdy = 1'b0;
                end
                else
                begin
                    rdy = 1'b1;
                end
            end
            ep_if.ready <= rdy;
        end
    end

endmodule
